// File: design/register_machine_execute_macros.svh
// Assertion macros shared by the register machine RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define REGISTER_MACHINE_EXECUTE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("register machine check failed");

// Next-cycle implication, checked outside reset.
`define RME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("register machine check failed");

`endif

// File: design/rme_pkg.sv
// Shared types and constants for the register machine execute block.
// No dependencies; imported by every module of the block.
package rme_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int IMM_WIDTH_DEF  = 16;
    localparam int OPND_W         = 16;
    localparam int CODE_W         = 4;
    localparam int SEL_W          = 2;
    localparam int OUT_W          = 32;
    localparam int MAP_W          = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } op_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
        logic [SEL_W-1:0]  dest;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] reg0;
        logic signed [OUT_W-1:0] reg1;
        logic signed [OUT_W-1:0] reg2;
        logic signed [OUT_W-1:0] reg3;
    } out_t;

    // Decoded instruction as it sits in the queue.
    typedef struct packed {
        op_t               op;
        logic [SEL_W-1:0]  sel_a;
        logic [SEL_W-1:0]  sel_b;
        logic [OPND_W-1:0] imm_a;
        logic [OPND_W-1:0] imm_b;
        logic [SEL_W-1:0]  dest;
    } dec_t;

    // Queue status toward the front and back.
    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

// File: design/rme_front.sv
// Front end: opcode map register and instruction decode.
// Depends on rme_pkg.
module rme_front
    import rme_pkg::*;
#(
    parameter int IMM_WIDTH = IMM_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [MAP_W-1:0] cfg_wdata,
    input  in_t              s_data,
    output dec_t             dec
);

    logic [MAP_W-1:0]  opcode_map_reg;
    logic [MAP_W-1:0]  opcode_map_next;
    logic [OPND_W-1:0] imm_a;
    logic [OPND_W-1:0] imm_b;

    always_comb begin
        opcode_map_next = cfg_we ? cfg_wdata : opcode_map_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcode_map_reg <= MAP_RESET;
        end else begin
            opcode_map_reg <= opcode_map_next;
        end
    end

    generate
        if (IMM_WIDTH >= OPND_W) begin : g_imm_full
            assign imm_a = s_data.operand_a;
            assign imm_b = s_data.operand_b;
        end else begin : g_imm_cut
            assign imm_a = OPND_W'(s_data.operand_a[IMM_WIDTH-1:0]);
            assign imm_b = OPND_W'(s_data.operand_b[IMM_WIDTH-1:0]);
        end
    endgenerate

    always_comb begin
        dec.op    = op_t'(opcode_map_reg[CODE_W*s_data.code +: CODE_W]);
        dec.sel_a = s_data.operand_a[SEL_W-1:0];
        dec.sel_b = s_data.operand_b[SEL_W-1:0];
        dec.imm_a = imm_a;
        dec.imm_b = imm_b;
        dec.dest  = s_data.dest;
    end

endmodule

// File: design/rme_queue.sv
// Short queue of decoded instructions between front and back.
// Depends on rme_pkg.
module rme_queue
    import rme_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  dec_t    push_data,
    input  logic    pop,
    output dec_t    pop_data,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dec_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);

endmodule

// File: design/rme_back.sv
// Back end: register file, ALU and output register.
// Depends on rme_pkg and register_machine_execute_macros.svh.
module rme_back
    import rme_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  dec_t q_data,
    output logic pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    `include "register_machine_execute_macros.svh"

    localparam int CMP_W = ((DATA_WIDTH > OPND_W) ? DATA_WIDTH : OPND_W) + 1;

    logic [3:0][DATA_WIDTH-1:0] regfile_reg, regfile_next;
    logic                       m_valid_reg, m_valid_next;
    out_t                       m_data_reg, m_data_next;

    logic [DATA_WIDTH-1:0]   ra, rb, ia, ib, result;
    logic [DATA_WIDTH-1:0]   prod_r, prod_i;
    logic signed [CMP_W-1:0] sa_c, sb_c, ia_c, ib_c;

    assign pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        ra     = regfile_reg[q_data.sel_a];
        rb     = regfile_reg[q_data.sel_b];
        ia     = DATA_WIDTH'(q_data.imm_a);
        ib     = DATA_WIDTH'(q_data.imm_b);
        // Only the low word of the product is kept.
        prod_r = ra * rb;
        prod_i = ra * ib;
        // Registers compare as signed, immediates as non-negative values.
        sa_c   = CMP_W'($signed(ra));
        sb_c   = CMP_W'($signed(rb));
        ia_c   = CMP_W'(q_data.imm_a);
        ib_c   = CMP_W'(q_data.imm_b);
    end

    always_comb begin
        case (q_data.op)
            OP_ADDR: result = DATA_WIDTH'(ra + rb);
            OP_ADDI: result = DATA_WIDTH'(ra + ib);
            OP_MULR: result = prod_r;
            OP_MULI: result = prod_i;
            OP_BANR: result = ra & rb;
            OP_BANI: result = ra & ib;
            OP_BORR: result = ra | rb;
            OP_BORI: result = ra | ib;
            OP_SETR: result = ra;
            OP_SETI: result = ia;
            OP_GTIR: result = DATA_WIDTH'(ia_c > sb_c);
            OP_GTRI: result = DATA_WIDTH'(sa_c > ib_c);
            OP_GTRR: result = DATA_WIDTH'(sa_c > sb_c);
            OP_EQIR: result = DATA_WIDTH'(ia_c == sb_c);
            OP_EQRI: result = DATA_WIDTH'(sa_c == ib_c);
            OP_EQRR: result = DATA_WIDTH'(sa_c == sb_c);
            default: result = '0;
        endcase
    end

    always_comb begin
        regfile_next = regfile_reg;
        if (pop) begin
            regfile_next[q_data.dest] = result;
        end
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_data_next = m_data_reg;
        if (pop) begin
            m_data_next.reg0 = OUT_W'($signed(regfile_next[0]));
            m_data_next.reg1 = OUT_W'($signed(regfile_next[1]));
            m_data_next.reg2 = OUT_W'($signed(regfile_next[2]));
            m_data_next.reg3 = OUT_W'($signed(regfile_next[3]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regfile_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            regfile_reg <= regfile_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RME_ASSERT_NEXT(a_pop_shows_result, aclk, aresetn, pop, m_valid_reg)
    `RME_ASSERT_NEXT(a_dest_written, aclk, aresetn, pop,
                     regfile_reg[$past(q_data.dest)] == $past(result))
    `RME_ASSERT_NEXT(a_regs_hold_idle, aclk, aresetn, !pop, $stable(regfile_reg))
    `RME_ASSERT_NOW(a_pop_needs_item, aclk, aresetn, pop, q_valid)

endmodule

// File: design/register_machine_execute.sv
// Four-register ALU machine: executes one instruction per transfer.
//
// Input channel s_valid/s_ready/s_data carries code, operand_a, operand_b
// and dest. The code goes through the opcode map (cfg_we/cfg_wdata, nibble k
// names the operation for code k) into one of sixteen operations. Write the
// map only while no instruction is in flight.
// Result channel m_valid/m_ready/m_data gives all four registers after each
// instruction, in order, one result per instruction.
// Throughput: one instruction per cycle while the receiver does not stall, set
// by the ALU and register file writeback in the back end. An instruction is
// held in a queue entry, then its result is held in the output register.
// A two-entry queue parts decode from execute; when the receiver stalls, the
// output register holds its result, the queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) clears all registers, restores the
// identity opcode map and empties the queue and output register.
// Depends on rme_pkg, rme_front, rme_queue, rme_back.
module register_machine_execute
    import rme_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IMM_WIDTH  = IMM_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [MAP_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    dec_t    dec;
    dec_t    q_data;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    rme_front #(
        .IMM_WIDTH (IMM_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .dec       (dec)
    );

    rme_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (dec),
        .pop       (pop),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    rme_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_stat.valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
